>>> sv/i8rsmv_pkg.sv
// Shared types and constants for the int8 row-scaled matrix-vector core.
`timescale 1ns / 1ps
package i8rsmv_pkg;

  localparam int CHUNK_W    = 7;   // chunk index / weight chunk position
  localparam int DATA_W     = 64;  // eight packed bytes
  localparam int BYTE_W     = 8;
  localparam int SCALE_W    = 24;  // unsigned Q8.16
  localparam int SUM_W      = 32;
  localparam int RES_W      = 48;
  localparam int ROW_W      = 16;
  localparam int PROD_W     = 2 * BYTE_W;
  localparam int FRAC_SHIFT = 32;  // both scales carry 16 fraction bits
  localparam int PART_W     = SUM_W + SCALE_W + 1;          // sum x half of scale product
  localparam int TOTAL_W    = SUM_W + 2 * SCALE_W + 1;      // full scaled product

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_WEIGHT = 1'b1
  } action_e;

  typedef struct packed {
    action_e              action;
    logic [CHUNK_W-1:0]   chunk_index;
    logic [DATA_W-1:0]    data_bytes;
    logic [SCALE_W-1:0]   scale_value;
    logic                 last_chunk;
    logic                 final_row;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot_sum;
    logic signed [RES_W-1:0] scaled_result;
    logic                    saturated;
    logic [ROW_W-1:0]        row_number;
    logic                    matrix_done;
  } out_t;

  // Per-item control that travels beside the lane data.
  typedef struct packed {
    logic               valid;
    logic               load;
    logic               last;
    logic               final_row;
    logic [ROW_W-1:0]   row_num;
    logic [SCALE_W-1:0] row_scale;
    logic [SCALE_W-1:0] act_scale;
  } ctl_t;

  // Finished row handed from the merge stage to the scale unit.
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [SCALE_W-1:0]      row_scale;
    logic [SCALE_W-1:0]      act_scale;
    logic [ROW_W-1:0]        row_num;
    logic                    final_row;
  } job_t;

endpackage

>>> sv/i8rsmv_lane.sv
// One multiply lane: signed weight byte times signed activation byte, registered.
`timescale 1ns / 1ps
module i8rsmv_lane (
  input  logic                                 clk_i,
  input  logic        [i8rsmv_pkg::BYTE_W-1:0] w_i,
  input  logic        [i8rsmv_pkg::BYTE_W-1:0] x_i,
  output logic signed [i8rsmv_pkg::PROD_W-1:0] prod_o
);

  logic signed [i8rsmv_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(w_i) * $signed(x_i);
  end

  assign prod_o = prod_q;

endmodule

>>> sv/i8rsmv_merge.sv
// Merge stage: adds the lane products and keeps the running row sum.
`timescale 1ns / 1ps
module i8rsmv_merge #(
  parameter int LANES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  i8rsmv_pkg::ctl_t                     ctl_i,
  input  logic signed [i8rsmv_pkg::PROD_W-1:0] prod_i [LANES],
  output i8rsmv_pkg::job_t                     job_o
);

  logic signed [i8rsmv_pkg::SUM_W-1:0] acc_q, acc_d;
  logic signed [i8rsmv_pkg::SUM_W-1:0] tree, row_sum;
  i8rsmv_pkg::job_t                    job_q, job_d;

  always_comb begin
    tree = '0;
    for (int l = 0; l < LANES; l++) begin
      tree = tree + i8rsmv_pkg::SUM_W'(prod_i[l]);
    end
    row_sum = acc_q + tree;  // wraps modulo 2^32

    acc_d           = acc_q;
    job_d           = '0;
    job_d.sum       = row_sum;
    job_d.row_scale = ctl_i.row_scale;
    job_d.act_scale = ctl_i.act_scale;
    job_d.row_num   = ctl_i.row_num;
    job_d.final_row = ctl_i.final_row;
    if (ctl_i.valid) begin
      if (ctl_i.load) begin
        acc_d = '0;
      end else if (ctl_i.last) begin
        acc_d       = '0;
        job_d.valid = 1'b1;
      end else begin
        acc_d = row_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      job_q <= '0;
    end else begin
      acc_q <= acc_d;
      job_q <= job_d;
    end
  end

  assign job_o = job_q;

  // A load always leaves an empty row sum behind it.
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid && ctl_i.load |=> acc_q == '0)
    else $error("row sum not cleared by load");

  // A finished row is registered and handed on for each closing chunk that passes, and only then.
  a_job_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_q.valid == $past(ctl_i.valid && !ctl_i.load && ctl_i.last))
    else $error("row hand-off out of step with closing chunk");

endmodule

>>> sv/i8rsmv_scale.sv
// Scale unit: row sum times both Q8.16 scales, floor shift by 32, clamp to 48 bits.
`timescale 1ns / 1ps
module i8rsmv_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  i8rsmv_pkg::job_t job_i,
  output i8rsmv_pkg::out_t res_o,
  output logic             res_valid_o,
  output logic             done_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_ADD
  } state_e;

  localparam int PW = 2 * i8rsmv_pkg::SCALE_W;
  localparam int SW = i8rsmv_pkg::TOTAL_W - i8rsmv_pkg::FRAC_SHIFT;

  state_e                                   state_q;
  logic [PW-1:0]                            p_q;
  logic signed [i8rsmv_pkg::SUM_W-1:0]      sum_q;
  logic [i8rsmv_pkg::ROW_W-1:0]             row_q;
  logic                                     fin_q;
  logic signed [i8rsmv_pkg::PART_W-1:0]     lo_q, hi_q;
  i8rsmv_pkg::out_t                         res_q;
  logic                                     res_valid_q;

  logic signed [i8rsmv_pkg::TOTAL_W-1:0]    total;
  logic signed [SW-1:0]                     shifted;
  logic                                     sat_hi, sat_lo;
  logic signed [i8rsmv_pkg::RES_W-1:0]      clamped;

  always_comb begin
    total = $signed({hi_q, {i8rsmv_pkg::SCALE_W{1'b0}}})
          + i8rsmv_pkg::TOTAL_W'(lo_q);
    // arithmetic shift: rounds toward minus infinity
    shifted = total[i8rsmv_pkg::TOTAL_W-1:i8rsmv_pkg::FRAC_SHIFT];
    sat_hi  = !shifted[SW-1] && (shifted[SW-2:i8rsmv_pkg::RES_W-1] != '0);
    sat_lo  = shifted[SW-1] && (shifted[SW-2:i8rsmv_pkg::RES_W-1] != '1);
    if (sat_hi) begin
      clamped = {1'b0, {(i8rsmv_pkg::RES_W-1){1'b1}}};
    end else if (sat_lo) begin
      clamped = {1'b1, {(i8rsmv_pkg::RES_W-1){1'b0}}};
    end else begin
      clamped = shifted[i8rsmv_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_i.valid) begin
            p_q     <= PW'(job_i.row_scale) * PW'(job_i.act_scale);
            sum_q   <= job_i.sum;
            row_q   <= job_i.row_num;
            fin_q   <= job_i.final_row;
            state_q <= ST_LO;
          end
        end
        ST_LO: begin
          lo_q    <= sum_q * $signed({1'b0, p_q[i8rsmv_pkg::SCALE_W-1:0]});
          state_q <= ST_HI;
        end
        ST_HI: begin
          hi_q    <= sum_q * $signed({1'b0, p_q[PW-1:i8rsmv_pkg::SCALE_W]});
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          res_q.dot_sum       <= sum_q;
          res_q.scaled_result <= clamped;
          res_q.saturated     <= sat_hi || sat_lo;
          res_q.row_number    <= row_q;
          res_q.matrix_done   <= fin_q;
          res_valid_q         <= 1'b1;
          state_q             <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
  assign done_o      = (state_q == ST_ADD);

  // The front end holds off new rows while one is being scaled.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_i.valid |-> state_q == ST_IDLE)
    else $error("row handed to scale unit while busy");

  a_strobe_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q) == ST_ADD)
    else $error("result strobe without final add");

endmodule

>>> sv/int8_row_scaled_matvec_core.sv
// Top level of the int8 row-scaled matrix-vector core.
//
//  channel   | signals                     | transfer when
//  ----------+-----------------------------+------------------------------
//  command   | cmd_i (in_t), start, busy   | start high and busy low
//  result    | res_o (out_t), res_valid_o  | every cycle res_valid_o is high
//
// Loads and weight chunks that do not close a row are taken one per cycle while busy is low.
// A row-closing weight chunk holds busy until the scale unit's final add, and its
// result strobes after 3 pipeline stages (store read, lane multiply, merge)
// then the scale unit's three multiplies and final add.
// Reset leaves the activation store reading as zero through per-chunk valid
// bits; no clearing pass is run. The receiver cannot stall the result.
`timescale 1ns / 1ps
module int8_row_scaled_matvec_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int LANES       = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  i8rsmv_pkg::in_t  cmd_i,
  output i8rsmv_pkg::out_t res_o,
  output logic             res_valid_o
);

  localparam int CHUNKS    = 2 ** i8rsmv_pkg::CHUNK_W;
  localparam int ROWS_NEED = (MAX_COLUMNS + LANES - 1) / LANES;
  localparam int DEPTH     = (ROWS_NEED < CHUNKS) ? ROWS_NEED : CHUNKS;
  localparam int AW        = $clog2(DEPTH);
  localparam int ROW_BITS  = LANES * i8rsmv_pkg::BYTE_W;

  logic [ROW_BITS-1:0]                mem_q [DEPTH];
  logic [DEPTH-1:0]                   valid_q;
  logic [i8rsmv_pkg::CHUNK_W-1:0]     pos_q;
  logic [i8rsmv_pkg::ROW_W-1:0]       row_cnt_q;
  logic [i8rsmv_pkg::SCALE_W-1:0]     act_scale_q;
  logic                               busy_q;
  i8rsmv_pkg::ctl_t                   s1_ctl_q, s2_ctl_q, s1_ctl_d;

  logic [ROW_BITS-1:0]                x_row_q, w_row_q;
  logic                               x_vld_q;
  logic [LANES-1:0]                   lane_en_q, lane_en_d;
  logic [i8rsmv_pkg::BYTE_W-1:0]      x_eff [LANES];
  logic signed [i8rsmv_pkg::PROD_W-1:0] prod [LANES];

  logic                               accept, is_load, wr_ok, sc_done;
  i8rsmv_pkg::job_t                   job;

  assign accept  = start && !busy_q;
  assign is_load = (cmd_i.action == i8rsmv_pkg::ACT_LOAD);
  assign wr_ok   = int'(cmd_i.chunk_index) < DEPTH;
  assign busy    = busy_q;

  always_comb begin
    // columns at or past MAX_COLUMNS contribute nothing
    for (int l = 0; l < LANES; l++) begin
      lane_en_d[l] = (int'(pos_q) * LANES + l) < MAX_COLUMNS;
    end
    s1_ctl_d           = '0;
    s1_ctl_d.valid     = accept;
    s1_ctl_d.load      = is_load;
    s1_ctl_d.last      = cmd_i.last_chunk && !is_load;
    s1_ctl_d.final_row = cmd_i.final_row;
    s1_ctl_d.row_num   = row_cnt_q;
    s1_ctl_d.row_scale = cmd_i.scale_value;
    s1_ctl_d.act_scale = act_scale_q;
  end

  // Activation store: one row of LANES bytes per chunk, registered read.
  always_ff @(posedge clk_i) begin
    if (accept && is_load && wr_ok) begin
      mem_q[cmd_i.chunk_index[AW-1:0]] <= cmd_i.data_bytes[ROW_BITS-1:0];
    end
    if (accept && !is_load) begin
      x_row_q   <= mem_q[pos_q[AW-1:0]];
      x_vld_q   <= valid_q[pos_q[AW-1:0]];
      w_row_q   <= cmd_i.data_bytes[ROW_BITS-1:0];
      lane_en_q <= lane_en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pos_q       <= '0;
      row_cnt_q   <= '0;
      act_scale_q <= '0;
      busy_q      <= 1'b0;
      s1_ctl_q    <= '0;
      s2_ctl_q    <= '0;
    end else begin
      s1_ctl_q <= s1_ctl_d;
      s2_ctl_q <= s1_ctl_q;
      if (sc_done) begin
        busy_q <= 1'b0;
      end
      if (accept) begin
        if (is_load) begin
          if (wr_ok) begin
            valid_q[cmd_i.chunk_index[AW-1:0]] <= 1'b1;
          end
          act_scale_q <= cmd_i.scale_value;
          pos_q       <= '0;
          row_cnt_q   <= '0;
        end else if (cmd_i.last_chunk) begin
          pos_q     <= '0;
          row_cnt_q <= row_cnt_q + 1'b1;
          busy_q    <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign x_eff[l] = (x_vld_q && lane_en_q[l])
                    ? x_row_q[l*i8rsmv_pkg::BYTE_W +: i8rsmv_pkg::BYTE_W]
                    : '0;
    i8rsmv_lane u_lane (
      .clk_i  (clk_i),
      .w_i    (w_row_q[l*i8rsmv_pkg::BYTE_W +: i8rsmv_pkg::BYTE_W]),
      .x_i    (x_eff[l]),
      .prod_o (prod[l])
    );
  end

  i8rsmv_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s2_ctl_q),
    .prod_i (prod),
    .job_o  (job)
  );

  i8rsmv_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .res_o       (res_o),
    .res_valid_o (res_valid_o),
    .done_o      (sc_done)
  );

  a_busy_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_load && cmd_i.last_chunk |=> busy_q)
    else $error("row-closing chunk did not raise busy");

  a_free_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_q)
    else $error("busy still high with result out");

  a_result_had_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> res_valid_o)
    else $error("busy dropped without a result");

endmodule

>>> tb/tb_int8_row_scaled_matvec_core.sv
// Self-checking testbench for the int8 row-scaled matrix-vector core.
`timescale 1ns / 1ps
module tb_int8_row_scaled_matvec_core;

  localparam int           STORE_DEPTH = 1024;
  localparam int           N_LANES     = 8;
  localparam int           RAND_ITEMS  = 450;
  localparam int           LONG_CHUNKS = 150;  // enough to wrap the chunk position
  localparam int           DRAIN_WAIT  = 12;
  localparam int           CYCLE_LIMIT = 3000000;
  localparam logic [63:0]  ALL_80      = 64'h8080808080808080;
  localparam logic [63:0]  ALL_7F      = 64'h7F7F7F7F7F7F7F7F;
  localparam logic [23:0]  SCALE_ONE   = 24'h010000;
  localparam logic [23:0]  SCALE_MAX   = 24'hFFFFFF;
  localparam longint       SCALED_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint       SCALED_LO   = -64'sh0000_8000_0000_0000;

  typedef struct {
    i8rsmv_pkg::in_t  cmd;
    bit               known;
    i8rsmv_pkg::out_t want;
  } step_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  i8rsmv_pkg::in_t  cmd_i;
  i8rsmv_pkg::out_t res_o;
  logic             res_valid_o;

  int          n_fail;
  int unsigned cycles;

  // predictor state
  logic signed [7:0]              act_bytes [STORE_DEPTH];
  logic [i8rsmv_pkg::SCALE_W-1:0] act_scale;
  logic [i8rsmv_pkg::SUM_W-1:0]   row_sum;
  logic [i8rsmv_pkg::CHUNK_W-1:0] chunk_pos;
  logic [i8rsmv_pkg::ROW_W-1:0]   row_cnt;

  i8rsmv_pkg::out_t row_results_q [$];
  step_t            steps [$];

  int8_row_scaled_matvec_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic i8rsmv_pkg::in_t cmd_of(i8rsmv_pkg::action_e act, int unsigned ch,
                                             logic [63:0] d, logic [23:0] s, bit last,
                                             bit fin);
    i8rsmv_pkg::in_t c;
    c.action      = act;
    c.chunk_index = ch[i8rsmv_pkg::CHUNK_W-1:0];
    c.data_bytes  = d;
    c.scale_value = s;
    c.last_chunk  = last;
    c.final_row   = fin;
    return c;
  endfunction

  // Advance the predictor by one accepted command; emits is set on a row close.
  function automatic void compute_row_result(input i8rsmv_pkg::in_t c, output bit emits,
                                             output i8rsmv_pkg::out_t r);
    logic signed [7:0]  w;
    logic signed [81:0] sum_x;
    logic signed [81:0] scl_x;
    logic signed [81:0] full;
    logic signed [81:0] shifted;
    int                 col;
    int                 prod;
    emits = 1'b0;
    r     = '0;
    if (c.action == i8rsmv_pkg::ACT_LOAD) begin
      for (int l = 0; l < N_LANES; l++) begin
        col = int'(c.chunk_index) * N_LANES + l;
        if (col < STORE_DEPTH) act_bytes[col] = c.data_bytes[8*l +: 8];
      end
      act_scale = c.scale_value;
      row_sum   = '0;
      chunk_pos = '0;
      row_cnt   = '0;
    end else begin
      for (int l = 0; l < N_LANES; l++) begin
        col = int'(chunk_pos) * N_LANES + l;
        if (col < STORE_DEPTH) begin
          w       = c.data_bytes[8*l +: 8];
          prod    = int'(w) * int'(act_bytes[col]);
          row_sum = row_sum + prod;
        end
      end
      chunk_pos = chunk_pos + 1'b1;
      if (c.last_chunk) begin
        sum_x   = $signed(row_sum);
        scl_x   = 82'(c.scale_value) * 82'(act_scale);
        full    = sum_x * scl_x;
        shifted = full >>> i8rsmv_pkg::FRAC_SHIFT;  // floor
        r.dot_sum     = row_sum;
        r.saturated   = 1'b0;
        if (shifted > SCALED_HI) begin
          shifted     = SCALED_HI;
          r.saturated = 1'b1;
        end else if (shifted < SCALED_LO) begin
          shifted     = SCALED_LO;
          r.saturated = 1'b1;
        end
        r.scaled_result = shifted[i8rsmv_pkg::RES_W-1:0];
        r.row_number    = row_cnt;
        r.matrix_done   = c.final_row;
        emits           = 1'b1;
        row_cnt         = row_cnt + 1'b1;
        row_sum         = '0;
        chunk_pos       = '0;
      end
    end
  endfunction

  // Drive one command after gap idle cycles and wait for its transfer.
  task automatic issue(input i8rsmv_pkg::in_t c, input int gap, input bit known = 1'b0,
                       input i8rsmv_pkg::out_t want = '0);
    bit               emits;
    i8rsmv_pkg::out_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    compute_row_result(c, emits, r);
    if (emits) row_results_q.push_back(known ? want : r);
  endtask

  function automatic logic [63:0] rand_bytes();
    logic [63:0] d;
    d = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      for (int l = 0; l < N_LANES; l++) begin
        case ($urandom_range(0, 4))
          0: d[8*l +: 8] = 8'h80;
          1: d[8*l +: 8] = 8'h7F;
          2: d[8*l +: 8] = 8'hFF;
          3: d[8*l +: 8] = 8'h00;
          default: d[8*l +: 8] = 8'h01;
        endcase
      end
    end
    return d;
  endfunction

  function automatic logic [23:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SCALE_MAX;
      2: return SCALE_ONE;
      default: return 24'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin : res_check
    i8rsmv_pkg::out_t want;
    if (rst_ni && res_valid_o) begin
      if (row_results_q.size() == 0) begin
        $error("unexpected result transfer, row_number %0d", res_o.row_number);
        n_fail++;
      end else begin
        want = row_results_q.pop_front();
        if (res_o.dot_sum !== want.dot_sum) begin
          $error("dot_sum: expected %0d, actual %0d", want.dot_sum, res_o.dot_sum);
          n_fail++;
        end
        if (res_o.scaled_result !== want.scaled_result) begin
          $error("scaled_result: expected %0d, actual %0d", want.scaled_result,
                 res_o.scaled_result);
          n_fail++;
        end
        if (res_o.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, res_o.saturated);
          n_fail++;
        end
        if (res_o.row_number !== want.row_number) begin
          $error("row_number: expected %0d, actual %0d", want.row_number,
                 res_o.row_number);
          n_fail++;
        end
        if (res_o.matrix_done !== want.matrix_done) begin
          $error("matrix_done: expected %0b, actual %0b", want.matrix_done,
                 res_o.matrix_done);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int              n_items;
    int              n_loads;
    int              n_rows;
    int              len;
    bit              no_idle;
    i8rsmv_pkg::in_t c;
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd_i     = '0;
    n_fail    = 0;
    cycles    = 0;
    act_scale = '0;
    row_sum   = '0;
    chunk_pos = '0;
    row_cnt   = '0;
    foreach (act_bytes[i]) act_bytes[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: store reads zero after reset, extremes, flags out of place
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_7F, SCALE_MAX, 1, 1),
                            1'b1,
                            i8rsmv_pkg::out_t'{32'sd0, 48'sd0, 1'b0, 16'd0, 1'b1}});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_LOAD, 0, ALL_80, SCALE_ONE, 0, 0),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_80, SCALE_ONE, 1, 0),
                            1'b1,
                            i8rsmv_pkg::out_t'{32'sd131072, 48'sd131072, 1'b0, 16'd0,
                                               1'b0}});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_7F, SCALE_ONE, 1, 1),
                            1'b1,
                            i8rsmv_pkg::out_t'{-32'sd130048, -48'sd130048, 1'b0, 16'd1,
                                               1'b1}});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_LOAD, 127, '1, SCALE_MAX, 1, 1),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 5, 64'h0101010101010101,
                                   SCALE_MAX, 0, 1), 1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 127, 64'h80FF7F0180FF7F01,
                                   '0, 0, 0), 1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_7F, '0, 1, 0),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_LOAD, 1, 64'h7F800001FF007F80,
                                   SCALE_MAX, 0, 0), 1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, 64'h0102040810204080,
                                   SCALE_ONE, 0, 0), 1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, 64'h80007FFF01807F01,
                                   SCALE_MAX, 1, 1), 1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_LOAD, 0, ALL_7F, SCALE_MAX, 0, 1),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_80, SCALE_MAX, 1, 0),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, '0, SCALE_MAX, 1, 1),
                            1'b1,
                            i8rsmv_pkg::out_t'{32'sd0, 48'sd0, 1'b0, 16'd1, 1'b1}});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_LOAD, 0, ALL_80, SCALE_MAX, 0, 0),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_80, SCALE_MAX, 1, 0),
                            1'b0, '0});
    steps.push_back(step_t'{cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_7F, SCALE_MAX, 1, 1),
                            1'b0, '0});
    foreach (steps[i]) issue(steps[i].cmd, $urandom_range(0, 17), steps[i].known,
                             steps[i].want);

    // one long row: chunk position wraps past 127
    for (int ch = 0; ch < 128; ch++)
      issue(cmd_of(i8rsmv_pkg::ACT_LOAD, ch, ALL_80, 24'h000100, 0, 0), 0);
    for (int i = 0; i < LONG_CHUNKS; i++)
      issue(cmd_of(i8rsmv_pkg::ACT_WEIGHT, 0, ALL_80, 24'h000100, i == LONG_CHUNKS - 1,
                   0), 0);

    // random: mostly well-formed matrices with random content, some noise
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        n_loads = $urandom_range(1, 4);
        for (int i = 0; i < n_loads; i++) begin
          c = cmd_of(i8rsmv_pkg::ACT_LOAD,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 7),
                     rand_bytes(), rand_scale(), $urandom_range(0, 1),
                     $urandom_range(0, 1));
          issue(c, no_idle ? 0 : $urandom_range(0, 17));
          n_items++;
        end
        n_rows = $urandom_range(1, 6);
        for (int r = 0; r < n_rows; r++) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140)
                                             : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            c = cmd_of(i8rsmv_pkg::ACT_WEIGHT, $urandom, rand_bytes(), rand_scale(),
                       k == len - 1,
                       (k == len - 1) ? (r == n_rows - 1) : $urandom_range(0, 1));
            issue(c, no_idle ? 0 : $urandom_range(0, 17));
            n_items++;
          end
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          c = cmd_of(i8rsmv_pkg::action_e'($urandom_range(0, 1)), $urandom, rand_bytes(),
                     24'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
          issue(c, no_idle ? 0 : $urandom_range(0, 17));
          n_items++;
        end
      end
    end

    start <= 1'b0;
    while (row_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
